@@ sv/rstab_pkg.sv @@
`default_nettype none
package rstab_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ID_W    = 10;
    localparam int SAL_W   = 25;
    localparam int SEC_W   = 3;
    localparam int OSLOT_W = 6;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_REMOVE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clear;
        logic hit;
        logic last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ sv/record_slot_table.sv @@
// a clear request skips the scan; insert, lookup and remove scan the slots from slot 0
// up to the first slot that qualifies, or through all SLOTS (64) slots when none
// qualifies, and then give their result
// one request at a time: the next is taken only after the result of the last one is
// loaded; the scan reads the slots one by one through the single read port of the slot memory
// reset: every slot empty, no result pending; slot contents stay as they were
`default_nettype none
module record_slot_table (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // id[9:0], salary[34:10], sector[37:35], zero[39:38]
    input  wire [rstab_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  wire [1:0]                            i_s_tuser,   // mode[1:0]
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    // slot[5:0], found_salary[30:6], found_sector[33:31]
    output logic [rstab_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                 o_m_tuser    // status
);

    rstab_pkg::t_cmd  w_cmd;
    rstab_pkg::t_stat w_stat;

    logic [rstab_pkg::OSLOT_W-1:0] w_slot;
    logic [rstab_pkg::SAL_W-1:0]   w_fsal;
    logic [rstab_pkg::SEC_W-1:0]   w_fsec;

    rstab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rstab_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_mode         (i_s_tuser),
        .i_id           (i_s_tdata[9:0]),
        .i_salary       (i_s_tdata[34:10]),
        .i_sector       (i_s_tdata[37:35]),
        .i_m_tready     (i_m_tready),
        .o_valid        (o_m_tvalid),
        .o_status       (o_m_tuser),
        .o_slot         (w_slot),
        .o_found_salary (w_fsal),
        .o_found_sector (w_fsec)
    );

    assign o_m_tdata = {6'd0, w_fsec, w_fsal, w_slot};

endmodule
`default_nettype wire

@@ sv/rstab_ctrl.sv @@
`default_nettype none
module rstab_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_tvalid,
    output logic               o_s_tready,
    input  rstab_pkg::t_stat   i_stat,
    output rstab_pkg::t_cmd    o_cmd
);

    rstab_pkg::t_state r_state;
    rstab_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rstab_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_s_tready   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            rstab_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.start = 1'b1;
                    n_state     = rstab_pkg::ST_SCAN;
                end
            end
            rstab_pkg::ST_SCAN: begin
                priority if (i_stat.clear) begin
                    n_state = rstab_pkg::ST_FINISH;
                end else if (i_stat.hit || i_stat.last) begin
                    o_cmd.scan = 1'b1;
                    n_state    = rstab_pkg::ST_FINISH;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            rstab_pkg::ST_FINISH: begin
                // hold the result until the output register can take it
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = rstab_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rstab_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/rstab_dp.sv @@
`default_nettype none
module rstab_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  rstab_pkg::t_cmd                    i_cmd,
    output rstab_pkg::t_stat                   o_stat,
    input  wire [1:0]                          i_mode,
    input  wire [rstab_pkg::ID_W-1:0]          i_id,
    input  wire [rstab_pkg::SAL_W-1:0]         i_salary,
    input  wire [rstab_pkg::SEC_W-1:0]         i_sector,
    input  wire                                i_m_tready,
    output logic                               o_valid,
    output logic                               o_status,
    output logic [rstab_pkg::OSLOT_W-1:0]      o_slot,
    output logic [rstab_pkg::SAL_W-1:0]        o_found_salary,
    output logic [rstab_pkg::SEC_W-1:0]        o_found_sector
);

    // request
    rstab_pkg::t_mode                r_mode;
    logic [rstab_pkg::ID_W-1:0]      r_id;
    logic [rstab_pkg::SAL_W-1:0]     r_sal;
    logic [rstab_pkg::SEC_W-1:0]     r_sec;

    // scan
    logic [rstab_pkg::SLOT_W-1:0]    r_addr;
    logic                            r_issue_done;
    logic                            r_p_vld;
    logic [rstab_pkg::SLOT_W-1:0]    r_p_idx;
    logic                            r_p_free;
    logic [rstab_pkg::ID_W-1:0]      r_rd_id;
    logic [rstab_pkg::SAL_W-1:0]     r_rd_sal;
    logic [rstab_pkg::SEC_W-1:0]     r_rd_sec;

    // match
    logic                            r_found;
    logic [rstab_pkg::SLOT_W-1:0]    r_res_idx;
    logic [rstab_pkg::SAL_W-1:0]     r_res_sal;
    logic [rstab_pkg::SEC_W-1:0]     r_res_sec;

    logic [rstab_pkg::SLOTS-1:0]     r_valid;

    logic [rstab_pkg::ID_W-1:0]      r_mem_id  [rstab_pkg::SLOTS];
    logic [rstab_pkg::SAL_W-1:0]     r_mem_sal [rstab_pkg::SLOTS];
    logic [rstab_pkg::SEC_W-1:0]     r_mem_sec [rstab_pkg::SLOTS];

    logic                            r_ovalid;
    logic                            r_ostatus;
    logic [rstab_pkg::OSLOT_W-1:0]   r_oslot;
    logic [rstab_pkg::SAL_W-1:0]     r_osal;
    logic [rstab_pkg::SEC_W-1:0]     r_osec;

    logic w_hit;
    logic w_issue;

    assign w_issue = i_cmd.scan && !r_issue_done;

    // insert wants the first empty slot, lookup and remove the first valid match
    assign w_hit = r_p_vld && ((r_mode == rstab_pkg::MODE_INSERT) ? r_p_free
                             : (!r_p_free && (r_rd_id == r_id)));

    assign o_stat.clear    = (r_mode == rstab_pkg::MODE_CLEAR);
    assign o_stat.hit      = w_hit;
    assign o_stat.last     = r_p_vld
                           && (r_p_idx == rstab_pkg::SLOT_W'(rstab_pkg::SLOTS - 1));
    assign o_stat.out_free = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode <= rstab_pkg::t_mode'(i_mode);
            r_id   <= i_id;
            r_sal  <= i_salary;
            r_sec  <= i_sector;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_p_vld      <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            r_p_vld <= w_issue;
            if (i_cmd.start) begin
                r_addr       <= '0;
                r_issue_done <= 1'b0;
                r_found      <= 1'b0;
            end else begin
                if (w_issue) begin
                    if (r_addr == rstab_pkg::SLOT_W'(rstab_pkg::SLOTS - 1)) begin
                        r_issue_done <= 1'b1;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                if (i_cmd.scan && w_hit) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_idx  <= r_addr;
        r_p_free <= !r_valid[r_addr];
        r_rd_id  <= r_mem_id[r_addr];
        r_rd_sal <= r_mem_sal[r_addr];
        r_rd_sec <= r_mem_sec[r_addr];
        if (i_cmd.scan && w_hit) begin
            r_res_idx <= r_p_idx;
            r_res_sal <= r_rd_sal;
            r_res_sec <= r_rd_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_mode == rstab_pkg::MODE_INSERT) && r_found) begin
            r_mem_id[r_res_idx]  <= r_id;
            r_mem_sal[r_res_idx] <= r_sal;
            r_mem_sec[r_res_idx] <= r_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit) begin
            unique case (r_mode)
                rstab_pkg::MODE_CLEAR: begin
                    r_valid <= '0;
                end
                rstab_pkg::MODE_INSERT: begin
                    if (r_found) begin
                        r_valid[r_res_idx] <= 1'b1;
                    end
                end
                rstab_pkg::MODE_REMOVE: begin
                    if (r_found) begin
                        r_valid[r_res_idx] <= 1'b0;
                    end
                end
                rstab_pkg::MODE_LOOKUP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ostatus <= (r_mode != rstab_pkg::MODE_CLEAR) && !r_found;
            r_oslot   <= r_found ? rstab_pkg::OSLOT_W'(r_res_idx) : '0;
            r_osal    <= (r_found && (r_mode == rstab_pkg::MODE_LOOKUP)) ? r_res_sal : '0;
            r_osec    <= (r_found && (r_mode == rstab_pkg::MODE_LOOKUP)) ? r_res_sec : '0;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_slot         = r_oslot;
    assign o_found_salary = r_osal;
    assign o_found_sector = r_osec;

    a_insert_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_mode == rstab_pkg::MODE_INSERT) && r_found)
        |=> r_valid[r_res_idx])
        else $error("inserted slot not marked valid");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_mode == rstab_pkg::MODE_CLEAR)) |=> (r_valid == '0))
        else $error("clear left a valid slot");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(i_cmd.commit))
        else $error("result appeared without a commit");

    a_remove_clears_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_mode == rstab_pkg::MODE_REMOVE) && r_found)
        |=> !r_valid[r_res_idx])
        else $error("removed slot still valid");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
module tb;

    localparam int IDLE_MAX       = 17;
    localparam int RANDOM_ITEMS   = 1450;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_MISS = 1'b1;

    localparam logic [rstab_pkg::ID_W-1:0]  ID_MAX  = '1;
    localparam logic [rstab_pkg::SAL_W-1:0] SAL_MAX = '1;
    localparam logic [rstab_pkg::SAL_W-1:0] SAL_TOP = 25'd20000000;
    localparam logic [rstab_pkg::SEC_W-1:0] SEC_MAX = '1;

    localparam int PHASE_FILL   = 0;
    localparam int PHASE_MIXED  = 1;
    localparam int PHASE_DUPS   = 2;
    localparam int PHASE_REMOVE = 3;

    typedef struct packed {
        logic                          status;
        logic [rstab_pkg::OSLOT_W-1:0] slot;
        logic [rstab_pkg::SAL_W-1:0]   salary;
        logic [rstab_pkg::SEC_W-1:0]   sector;
    } t_table_result;

    typedef struct {
        rstab_pkg::t_mode            mode;
        logic [rstab_pkg::ID_W-1:0]  id;
        logic [rstab_pkg::SAL_W-1:0] salary;
        logic [rstab_pkg::SEC_W-1:0] sector;
        bit                          typed;
        t_table_result               result;
    } t_directed_row;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [39:0] m_tdata;
    wire         m_tuser;

    record_slot_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    // shadow copy of the slot table
    bit                          table_valid  [rstab_pkg::SLOTS];
    logic [rstab_pkg::ID_W-1:0]  table_id     [rstab_pkg::SLOTS];
    logic [rstab_pkg::SAL_W-1:0] table_salary [rstab_pkg::SLOTS];
    logic [rstab_pkg::SEC_W-1:0] table_sector [rstab_pkg::SLOTS];

    t_table_result pending_results[$];
    t_directed_row directed_rows[$];

    int  error_count = 0;
    int  mode_count[4] = '{0, 0, 0, 0};
    int  full_count = 0;
    int  miss_count = 0;
    int  stall_left = 0;
    int  idle_cycles = 0;
    bit  rx_steady = 1'b0;

    always #4 i_clk = ~i_clk;

    function automatic t_table_result apply_request(rstab_pkg::t_mode mode,
                                                    logic [rstab_pkg::ID_W-1:0] id,
                                                    logic [rstab_pkg::SAL_W-1:0] salary,
                                                    logic [rstab_pkg::SEC_W-1:0] sector);
        t_table_result res = '0;
        int hit = -1;
        mode_count[mode]++;
        case (mode)
            rstab_pkg::MODE_CLEAR: begin
                foreach (table_valid[i]) table_valid[i] = 1'b0;
            end
            rstab_pkg::MODE_INSERT: begin
                for (int i = 0; i < rstab_pkg::SLOTS; i++)
                    if (!table_valid[i] && hit < 0) hit = i;
                if (hit >= 0) begin
                    table_valid[hit]  = 1'b1;
                    table_id[hit]     = id;
                    table_salary[hit] = salary;
                    table_sector[hit] = sector;
                    res.slot = hit[rstab_pkg::OSLOT_W-1:0];
                end else begin
                    res.status = STATUS_MISS;
                    full_count++;
                end
            end
            default: begin
                for (int i = 0; i < rstab_pkg::SLOTS; i++)
                    if (table_valid[i] && table_id[i] == id && hit < 0) hit = i;
                if (hit < 0) begin
                    res.status = STATUS_MISS;
                    miss_count++;
                end else begin
                    res.slot = hit[rstab_pkg::OSLOT_W-1:0];
                    if (mode == rstab_pkg::MODE_LOOKUP) begin
                        res.salary = table_salary[hit];
                        res.sector = table_sector[hit];
                    end else begin
                        table_valid[hit] = 1'b0;
                    end
                end
            end
        endcase
        return res;
    endfunction

    // mostly ids that are live in the table so lookups and removes hit; narrow picks ids 0 to 7
    function automatic logic [rstab_pkg::ID_W-1:0] pick_id(bit narrow);
        int live[$];
        for (int i = 0; i < rstab_pkg::SLOTS; i++)
            if (table_valid[i]) live.push_back(i);
        if (narrow)
            return rstab_pkg::ID_W'($urandom_range(0, 7));
        if (live.size() > 0 && $urandom_range(0, 3) != 0)
            return table_id[live[$urandom_range(0, live.size() - 1)]];
        return rstab_pkg::ID_W'($urandom_range(0, (1 << rstab_pkg::ID_W) - 1));
    endfunction

    function automatic logic [rstab_pkg::SAL_W-1:0] pick_salary();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SAL_TOP;
            2:       return SAL_MAX;
            3:       return rstab_pkg::SAL_W'($urandom_range(0, (1 << rstab_pkg::SAL_W) - 1));
            default: return rstab_pkg::SAL_W'($urandom_range(0, 20000000));
        endcase
    endfunction

    task automatic add_row(rstab_pkg::t_mode mode, logic [rstab_pkg::ID_W-1:0] id,
                           logic [rstab_pkg::SAL_W-1:0] salary,
                           logic [rstab_pkg::SEC_W-1:0] sector, bit typed,
                           logic status = STATUS_OK,
                           logic [rstab_pkg::OSLOT_W-1:0] slot = '0,
                           logic [rstab_pkg::SAL_W-1:0] fsal = '0,
                           logic [rstab_pkg::SEC_W-1:0] fsec = '0);
        t_directed_row row;
        row.mode   = mode;
        row.id     = id;
        row.salary = salary;
        row.sector = sector;
        row.typed  = typed;
        row.result = '{status, slot, fsal, fsec};
        directed_rows.push_back(row);
    endtask

    // called just after a rising edge; returns at the edge that took the request
    task automatic send_request(rstab_pkg::t_mode mode, logic [rstab_pkg::ID_W-1:0] id,
                                logic [rstab_pkg::SAL_W-1:0] salary,
                                logic [rstab_pkg::SEC_W-1:0] sector, bit no_gap,
                                bit typed = 1'b0, t_table_result typed_result = '0);
        int gap;
        t_table_result predicted;
        gap = no_gap ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, sector, salary, id};
        do @(posedge i_clk); while (!s_tready);
        predicted = apply_request(mode, id, salary, sector);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin : result_check
        t_table_result want;
        int stall;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[5:0] !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, m_tdata[5:0]);
                    error_count++;
                end
                if (m_tdata[30:6] !== want.salary) begin
                    $error("found_salary: expected %0d, got %0d", want.salary, m_tdata[30:6]);
                    error_count++;
                end
                if (m_tdata[33:31] !== want.sector) begin
                    $error("found_sector: expected %0d, got %0d", want.sector, m_tdata[33:31]);
                    error_count++;
                end
            end
            stall = rx_steady ? 0 : $urandom_range(0, IDLE_MAX);
            if (stall > 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall - 1;
            end
        end else if (!m_tready) begin
            if (stall_left == 0)
                m_tready <= 1'b1;
            else
                stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int sent;
        int phase;
        int phase_kind;
        int phase_len;
        int r;
        bit burst;
        rstab_pkg::t_mode mode;

        // after reset nothing can be found; then inserts fill slots 0 and 1
        add_row(rstab_pkg::MODE_LOOKUP, '0, '0, '0, 1'b1, STATUS_MISS);
        add_row(rstab_pkg::MODE_REMOVE, ID_MAX, '0, '0, 1'b1, STATUS_MISS);
        add_row(rstab_pkg::MODE_INSERT, '0, '0, '0, 1'b1, STATUS_OK, 6'd0);
        add_row(rstab_pkg::MODE_INSERT, ID_MAX, SAL_MAX, SEC_MAX, 1'b1, STATUS_OK, 6'd1);
        add_row(rstab_pkg::MODE_LOOKUP, ID_MAX, '0, '0, 1'b1, STATUS_OK, 6'd1,
                SAL_MAX, SEC_MAX);
        // duplicate id: lookup and remove act on the lowest matching slot
        add_row(rstab_pkg::MODE_INSERT, ID_MAX, SAL_TOP, 3'd6, 1'b0);
        add_row(rstab_pkg::MODE_LOOKUP, ID_MAX, '0, '0, 1'b0);
        add_row(rstab_pkg::MODE_REMOVE, ID_MAX, '0, '0, 1'b0);
        add_row(rstab_pkg::MODE_LOOKUP, ID_MAX, '0, '0, 1'b0);
        add_row(rstab_pkg::MODE_REMOVE, ID_MAX, '0, '0, 1'b0);
        add_row(rstab_pkg::MODE_REMOVE, ID_MAX, '0, '0, 1'b1, STATUS_MISS);
        // freed slots are reused lowest first
        add_row(rstab_pkg::MODE_INSERT, 10'h2AA, 25'h0AAAAAA, 3'd1, 1'b0);
        add_row(rstab_pkg::MODE_INSERT, 10'h155, 25'h1555555, 3'd5, 1'b0);
        add_row(rstab_pkg::MODE_LOOKUP, 10'h155, '0, '0, 1'b0);
        add_row(rstab_pkg::MODE_LOOKUP, '0, SAL_MAX, SEC_MAX, 1'b0);
        add_row(rstab_pkg::MODE_CLEAR, ID_MAX, SAL_MAX, SEC_MAX, 1'b1, STATUS_OK);
        add_row(rstab_pkg::MODE_LOOKUP, '0, '0, '0, 1'b1, STATUS_MISS);
        add_row(rstab_pkg::MODE_INSERT, 10'd512, 25'd1, 3'd2, 1'b1, STATUS_OK, 6'd0);
        add_row(rstab_pkg::MODE_LOOKUP, 10'd512, '0, '0, 1'b0);
        add_row(rstab_pkg::MODE_CLEAR, '0, '0, '0, 1'b1, STATUS_OK);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].mode, directed_rows[i].id, directed_rows[i].salary,
                         directed_rows[i].sector, 1'b0, directed_rows[i].typed,
                         directed_rows[i].result);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_kind = (phase == 0) ? PHASE_FILL : $urandom_range(PHASE_FILL, PHASE_REMOVE);
            phase_len  = (phase == 0) ? 72 : $urandom_range(30, 120);
            burst      = ($urandom_range(0, 3) == 0);
            rx_steady  <= ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                case (phase_kind)
                    PHASE_FILL:
                        mode = (phase == 0 || r < 85) ? rstab_pkg::MODE_INSERT :
                               (r < 93) ? rstab_pkg::MODE_LOOKUP : rstab_pkg::MODE_REMOVE;
                    PHASE_REMOVE:
                        mode = (r < 20) ? rstab_pkg::MODE_INSERT :
                               (r < 50) ? rstab_pkg::MODE_LOOKUP : rstab_pkg::MODE_REMOVE;
                    default:
                        mode = (r < 3) ? rstab_pkg::MODE_CLEAR :
                               (r < 38) ? rstab_pkg::MODE_INSERT :
                               (r < 73) ? rstab_pkg::MODE_LOOKUP : rstab_pkg::MODE_REMOVE;
                endcase
                send_request(mode, pick_id(phase_kind == PHASE_DUPS), pick_salary(),
                             rstab_pkg::SEC_W'($urandom_range(0, 7)), burst);
                sent++;
            end
            // let the table go idle between some phases
            if (phase == 0 || $urandom_range(0, 2) == 0)
                wait_drained();
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d requests: clear %0d, insert %0d, lookup %0d, remove %0d",
                 mode_count[rstab_pkg::MODE_CLEAR] + mode_count[rstab_pkg::MODE_INSERT] +
                 mode_count[rstab_pkg::MODE_LOOKUP] + mode_count[rstab_pkg::MODE_REMOVE],
                 mode_count[rstab_pkg::MODE_CLEAR], mode_count[rstab_pkg::MODE_INSERT],
                 mode_count[rstab_pkg::MODE_LOOKUP], mode_count[rstab_pkg::MODE_REMOVE]);
        $display("summary: %0d table-full, %0d id-miss outcomes, %0d mismatches",
                 full_count, miss_count, error_count);
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/rstab_pkg.sv
sv/rstab_ctrl.sv
sv/rstab_dp.sv
sv/record_slot_table.sv
tb/sv/tb.sv
